// ===== hw/rtl/periodic_timer_heap_scheduler_core_assert.svh =====
// Assertion macros for the periodic timer heap scheduler
`ifndef PERIODIC_TIMER_HEAP_SCHEDULER_CORE_ASSERT_SVH
`define PERIODIC_TIMER_HEAP_SCHEDULER_CORE_ASSERT_SVH

// check a condition at every clock edge out of reset
`define PTHS_ASSERT_ALWAYS(lbl, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (c)) \
		else $error("pths assertion failed");

// check that an antecedent implies a consequent in the same cycle
`define PTHS_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("pths assertion failed");

`endif

// ===== hw/rtl/pths_pkg.sv =====
// Package: constants, types and helpers of the periodic timer heap scheduler
`timescale 1ns / 1ps
`default_nettype none
package pths_pkg;
	localparam int TIMER_SLOTS = 32;
	localparam int SLOT_W = $clog2(TIMER_SLOTS);
	localparam int HEAP_DEPTH = 64;
	localparam int IDX_W = $clog2(HEAP_DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int STAMP_W = 16;
	localparam int TAG_W = STAMP_W + SLOT_W;
	localparam int TIME_W = 64;

	localparam logic [1:0] CMD_REG = 2'd0;
	localparam logic [1:0] CMD_REARM = 2'd1;
	localparam logic [1:0] CMD_REL = 2'd2;
	localparam logic [1:0] CMD_PUMP = 2'd3;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FIRED = 3'd1;
	localparam logic [2:0] ST_REGISTERED = 3'd2;
	localparam logic [2:0] ST_REARMED = 3'd3;
	localparam logic [2:0] ST_RELEASED = 3'd4;
	localparam logic [2:0] ST_NO_SLOT = 3'd5;
	localparam logic [2:0] ST_HEAP_FULL = 3'd6;
	localparam logic [2:0] ST_BAD_ID = 3'd7;

	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE = 4'd0;
	localparam logic [OP_W-1:0] OP_DEC = 4'd1;
	localparam logic [OP_W-1:0] OP_PU_RD = 4'd2;
	localparam logic [OP_W-1:0] OP_PU_CMP = 4'd3;
	localparam logic [OP_W-1:0] OP_PU_WR = 4'd4;
	localparam logic [OP_W-1:0] OP_RT_RD = 4'd5;
	localparam logic [OP_W-1:0] OP_RT_CHK = 4'd6;
	localparam logic [OP_W-1:0] OP_PO_LD = 4'd7;
	localparam logic [OP_W-1:0] OP_PO_L = 4'd8;
	localparam logic [OP_W-1:0] OP_PO_R = 4'd9;
	localparam logic [OP_W-1:0] OP_PO_CMP = 4'd10;
	localparam logic [OP_W-1:0] OP_PO_WR = 4'd11;

	typedef struct packed {
		logic [1:0] cmd;
		logic [4:0] timer_id;
		logic [TIME_W-1:0] deadline;
		logic relative;
		logic [TIME_W-1:0] period;
		logic keep_period;
		logic kind_flag;
		logic [TIME_W-1:0] now;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] timer_id_res;
		logic [TIME_W-1:0] fire_time;
		logic [TIME_W-1:0] fire_period;
		logic fire_kind;
	} res_t;

	typedef struct packed {
		logic [TIME_W-1:0] dl;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic load;
	} ctl_t;

	typedef struct packed {
		logic push;
		logic pump;
		logic i_zero;
		logic pu_less;
		logic not_due;
		logic l_out;
		logic m_less;
		logic repush;
		logic live;
		logic cnt_zero;
	} sts_t;

	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
			input logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? '1 : s[TIME_W-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/pths_if.sv =====
// Interfaces: command and result channels of the timer scheduler
`timescale 1ns / 1ps
`default_nettype none
interface pths_req_if;
	logic valid;
	logic ready;
	pths_pkg::item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pths_rsp_if;
	logic valid;
	logic ready;
	pths_pkg::res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pths_ctrl.sv =====
// Controller: sequences command decode, heap sift-up, sift-down and pump loop
`timescale 1ns / 1ps
`default_nettype none
module pths_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire pths_pkg::sts_t sts,
	output pths_pkg::ctl_t ctl
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC = 4'd1;
	localparam logic [3:0] S_PU_RD = 4'd2;
	localparam logic [3:0] S_PU_CMP = 4'd3;
	localparam logic [3:0] S_PU_WR = 4'd4;
	localparam logic [3:0] S_RT_RD = 4'd5;
	localparam logic [3:0] S_RT_CHK = 4'd6;
	localparam logic [3:0] S_PO_LD = 4'd7;
	localparam logic [3:0] S_PO_L = 4'd8;
	localparam logic [3:0] S_PO_R = 4'd9;
	localparam logic [3:0] S_PO_CMP = 4'd10;
	localparam logic [3:0] S_PO_WR = 4'd11;
	localparam logic [3:0] S_OUT = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		ctl.op = pths_pkg::OP_NONE;
		ctl.load = in_ready && in_valid;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DEC;
			end
			S_DEC: begin
				ctl.op = pths_pkg::OP_DEC;
				if (sts.push) state_d = S_PU_RD;
				else if (sts.pump) state_d = S_RT_CHK;
				else state_d = S_OUT;
			end
			S_PU_RD: begin
				ctl.op = pths_pkg::OP_PU_RD;
				state_d = sts.i_zero ? S_PU_WR : S_PU_CMP;
			end
			S_PU_CMP: begin
				ctl.op = pths_pkg::OP_PU_CMP;
				state_d = sts.pu_less ? S_PU_RD : S_PU_WR;
			end
			S_PU_WR: begin
				ctl.op = pths_pkg::OP_PU_WR;
				state_d = S_OUT;
			end
			S_RT_RD: begin
				ctl.op = pths_pkg::OP_RT_RD;
				state_d = S_RT_CHK;
			end
			S_RT_CHK: begin
				ctl.op = pths_pkg::OP_RT_CHK;
				state_d = sts.not_due ? S_OUT : S_PO_LD;
			end
			S_PO_LD: begin
				ctl.op = pths_pkg::OP_PO_LD;
				state_d = S_PO_L;
			end
			S_PO_L: begin
				ctl.op = pths_pkg::OP_PO_L;
				state_d = sts.l_out ? S_PO_WR : S_PO_R;
			end
			S_PO_R: begin
				ctl.op = pths_pkg::OP_PO_R;
				state_d = S_PO_CMP;
			end
			S_PO_CMP: begin
				ctl.op = pths_pkg::OP_PO_CMP;
				state_d = sts.m_less ? S_PO_L : S_PO_WR;
			end
			S_PO_WR: begin
				ctl.op = pths_pkg::OP_PO_WR;
				if (sts.repush) state_d = S_PU_RD;
				else if (sts.live || sts.cnt_zero) state_d = S_OUT;
				else state_d = S_RT_RD;
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/pths_dp.sv =====
// Datapath: slot table, heap memory, sift registers and result register
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_timer_heap_scheduler_core_assert.svh"
module pths_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire pths_pkg::ctl_t ctl,
	input wire pths_pkg::item_t in_data,
	output pths_pkg::sts_t sts,
	output pths_pkg::res_t res
);
	pths_pkg::entry_t heap_mem [pths_pkg::HEAP_DEPTH];
	pths_pkg::entry_t rd_q, cur_q, lch_q, fire_q, wd, m_ent;
	pths_pkg::item_t item_q;
	pths_pkg::res_t res_q;

	logic [pths_pkg::TIMER_SLOTS-1:0] slot_valid_q, slot_kind_q;
	logic [pths_pkg::STAMP_W-1:0] slot_stamp_q [pths_pkg::TIMER_SLOTS];
	logic [pths_pkg::TIME_W-1:0] slot_period_q [pths_pkg::TIMER_SLOTS];
	logic [pths_pkg::CNT_W-1:0] cnt_q;
	logic [pths_pkg::IDX_W-1:0] idx_q, par_idx, m_idx, wa, ra;
	logic has_r_q, live_q, we;

	logic [pths_pkg::TIME_W-1:0] first;
	logic free_found, full, id_ok, pick_r, live, wr_op;
	logic [pths_pkg::SLOT_W-1:0] free_slot, rs, id;
	logic [pths_pkg::STAMP_W-1:0] rsp;
	logic [pths_pkg::CNT_W:0] lft, rgt;

	assign id = item_q.timer_id;
	assign first = item_q.relative ? pths_pkg::sat_add(item_q.now, item_q.deadline)
		: item_q.deadline;
	assign full = (cnt_q == pths_pkg::CNT_W'(pths_pkg::HEAP_DEPTH));
	assign id_ok = slot_valid_q[id];
	assign par_idx = (idx_q - 1'b1) >> 1;
	assign lft = {1'b0, idx_q, 1'b1};
	assign rgt = lft + 1'b1;
	assign rs = rd_q.tag[pths_pkg::SLOT_W-1:0];
	assign rsp = rd_q.tag[pths_pkg::TAG_W-1:pths_pkg::SLOT_W];
	assign live = slot_valid_q[rs] && (slot_stamp_q[rs] == rsp);
	assign pick_r = has_r_q && (rd_q.dl < lch_q.dl);
	assign m_ent = pick_r ? rd_q : lch_q;
	assign m_idx = pick_r ? rgt[pths_pkg::IDX_W-1:0] : lft[pths_pkg::IDX_W-1:0];
	assign wr_op = (ctl.op == pths_pkg::OP_PU_CMP) || (ctl.op == pths_pkg::OP_PU_WR)
		|| (ctl.op == pths_pkg::OP_PO_CMP) || (ctl.op == pths_pkg::OP_PO_WR);

	always_comb begin
		free_found = 1'b0;
		free_slot = '0;
		for (int k = pths_pkg::TIMER_SLOTS - 1; k >= 0; k--) begin
			if (!slot_valid_q[k]) begin
				free_found = 1'b1;
				free_slot = pths_pkg::SLOT_W'(k);
			end
		end
	end

	always_comb begin
		sts.push = 1'b0;
		case (item_q.cmd)
			pths_pkg::CMD_REG: sts.push = !full && free_found;
			pths_pkg::CMD_REARM: sts.push = !full && id_ok;
			default: sts.push = 1'b0;
		endcase
		sts.pump = (item_q.cmd == pths_pkg::CMD_PUMP) && (cnt_q != '0);
		sts.i_zero = (idx_q == '0);
		sts.pu_less = cur_q.dl < rd_q.dl;
		sts.not_due = item_q.now < rd_q.dl;
		sts.l_out = lft >= {1'b0, cnt_q};
		sts.m_less = m_ent.dl < cur_q.dl;
		sts.repush = live_q && (res_q.fire_period != '0);
		sts.live = live_q;
		sts.cnt_zero = (cnt_q == '0);
	end

	always_comb begin
		we = 1'b0;
		wa = idx_q;
		wd = cur_q;
		ra = '0;
		case (ctl.op)
			pths_pkg::OP_PU_RD: ra = par_idx;
			pths_pkg::OP_PU_CMP: begin
				we = sts.pu_less;
				wd = rd_q;
			end
			pths_pkg::OP_PU_WR: we = 1'b1;
			pths_pkg::OP_RT_CHK: ra = pths_pkg::IDX_W'(cnt_q - 1'b1);
			pths_pkg::OP_PO_L: ra = lft[pths_pkg::IDX_W-1:0];
			pths_pkg::OP_PO_R: ra = rgt[pths_pkg::IDX_W-1:0];
			pths_pkg::OP_PO_CMP: begin
				we = sts.m_less;
				wd = m_ent;
			end
			pths_pkg::OP_PO_WR: we = 1'b1;
			default: ra = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) heap_mem[wa] <= wd;
		rd_q <= heap_mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			slot_valid_q <= '0;
			for (int k = 0; k < pths_pkg::TIMER_SLOTS; k++) slot_stamp_q[k] <= '0;
		end else begin
			case (ctl.op)
				pths_pkg::OP_DEC: begin
					if (sts.push) cnt_q <= cnt_q + 1'b1;
					if (item_q.cmd == pths_pkg::CMD_REG && sts.push) begin
						slot_valid_q[free_slot] <= 1'b1;
					end
					if (item_q.cmd == pths_pkg::CMD_REL && id_ok) begin
						slot_valid_q[id] <= 1'b0;
						slot_stamp_q[id] <= slot_stamp_q[id] + 1'b1;
					end
					if (item_q.cmd == pths_pkg::CMD_REARM && sts.push) begin
						slot_stamp_q[id] <= slot_stamp_q[id] + 1'b1;
					end
				end
				pths_pkg::OP_RT_CHK: begin
					if (!sts.not_due) cnt_q <= cnt_q - 1'b1;
				end
				pths_pkg::OP_PO_WR: begin
					if (sts.repush) cnt_q <= cnt_q + 1'b1;
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= in_data;
			res_q <= '0;
		end
		case (ctl.op)
			pths_pkg::OP_DEC: begin
				case (item_q.cmd)
					pths_pkg::CMD_REG: begin
						if (full) res_q.status <= pths_pkg::ST_HEAP_FULL;
						else if (!free_found) res_q.status <= pths_pkg::ST_NO_SLOT;
						else begin
							slot_period_q[free_slot] <= item_q.period;
							slot_kind_q[free_slot] <= item_q.kind_flag;
							cur_q <= '{dl: first, tag: {slot_stamp_q[free_slot], free_slot}};
							idx_q <= cnt_q[pths_pkg::IDX_W-1:0];
							res_q.status <= pths_pkg::ST_REGISTERED;
							res_q.timer_id_res <= free_slot;
						end
					end
					pths_pkg::CMD_REARM, pths_pkg::CMD_REL: begin
						res_q.timer_id_res <= id;
						if (!id_ok) res_q.status <= pths_pkg::ST_BAD_ID;
						else if (item_q.cmd == pths_pkg::CMD_REL) begin
							res_q.status <= pths_pkg::ST_RELEASED;
						end else if (full) res_q.status <= pths_pkg::ST_HEAP_FULL;
						else begin
							if (!item_q.keep_period) slot_period_q[id] <= item_q.period;
							cur_q <= '{dl: first, tag: {slot_stamp_q[id] + 1'b1, id}};
							idx_q <= cnt_q[pths_pkg::IDX_W-1:0];
							res_q.status <= pths_pkg::ST_REARMED;
						end
					end
					default: res_q.status <= pths_pkg::ST_IDLE;
				endcase
			end
			pths_pkg::OP_PU_CMP: begin
				if (sts.pu_less) idx_q <= par_idx;
			end
			pths_pkg::OP_RT_CHK: begin
				if (!sts.not_due) begin
					fire_q <= rd_q;
					live_q <= live;
					if (live) begin
						res_q.status <= pths_pkg::ST_FIRED;
						res_q.timer_id_res <= rs;
						res_q.fire_time <= item_q.now;
						res_q.fire_period <= slot_period_q[rs];
						res_q.fire_kind <= slot_kind_q[rs];
					end
				end
			end
			pths_pkg::OP_PO_LD: begin
				cur_q <= rd_q;
				idx_q <= '0;
			end
			pths_pkg::OP_PO_R: begin
				lch_q <= rd_q;
				has_r_q <= rgt < {1'b0, cnt_q};
			end
			pths_pkg::OP_PO_CMP: begin
				if (sts.m_less) idx_q <= m_idx;
			end
			pths_pkg::OP_PO_WR: begin
				if (sts.repush) begin
					cur_q <= '{dl: pths_pkg::sat_add(fire_q.dl, res_q.fire_period),
						tag: fire_q.tag};
					idx_q <= cnt_q[pths_pkg::IDX_W-1:0];
				end
			end
			default: idx_q <= idx_q;
		endcase
	end

	assign res = res_q;

	`PTHS_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= pths_pkg::CNT_W'(pths_pkg::HEAP_DEPTH))
	`PTHS_ASSERT_IMP(a_write_op, we, wr_op)
	`PTHS_ASSERT_IMP(a_push_nonempty, ctl.op == pths_pkg::OP_PU_WR, cnt_q != '0)
endmodule
`default_nettype wire

// ===== hw/rtl/periodic_timer_heap_scheduler_core.sv =====
// Top level: min-heap timer queue, controller plus datapath
//
// Channel  Dir  Payload
// req      in   cmd, timer_id, deadline, relative, period, keep_period, kind_flag, now
// rsp      out  status, timer_id_res, fire_time, fire_period, fire_kind
//
// One item at a time; a result is held in rsp until taken, then req opens again.
// Register/rearm: decode, a parent read and compare per level climbed (and a last one
// when the climb stops below the root), then the write. Pump: decode and a root check
// when nothing is due; each popped entry adds a load of the last entry, a left read,
// right read and compare per level sunk, and a write; stale entries reread the root,
// a fired periodic timer adds a sift-up. Reset clears slot valid bits, stamps and count.
`timescale 1ns / 1ps
`default_nettype none
module periodic_timer_heap_scheduler_core (
	input wire logic clk,
	input wire logic arst_n,
	pths_req_if.sink req,
	pths_rsp_if.source rsp
);
	pths_pkg::ctl_t ctl;
	pths_pkg::sts_t sts;

	pths_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.sts(sts),
		.ctl(ctl)
	);

	pths_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.in_data(req.data),
		.sts(sts),
		.res(rsp.data)
	);
endmodule
`default_nettype wire

// ===== tb/pths_checker.sv =====
// Checker: watches the timer scheduler channels, predicts each result and compares
`timescale 1ns / 1ps
module pths_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input pths_pkg::item_t req_data,
	input logic rsp_valid,
	input logic rsp_ready,
	input pths_pkg::res_t rsp_data,
	output int errors,
	output int pending,
	output int fired_cnt
);
	import pths_pkg::*;

	logic slot_live [TIMER_SLOTS];
	logic [TIME_W-1:0] slot_per [TIMER_SLOTS];
	logic [STAMP_W-1:0] slot_stmp [TIMER_SLOTS];
	logic slot_low [TIMER_SLOTS];
	logic [TIME_W-1:0] q_dl [HEAP_DEPTH];
	logic [TAG_W-1:0] q_tag [HEAP_DEPTH];
	int q_cnt;
	res_t expected_q [$];

	assign pending = expected_q.size();

	task automatic report(input string what, input logic [TIME_W-1:0] got,
			input logic [TIME_W-1:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void q_swap(input int a, input int b);
		logic [TIME_W-1:0] d;
		logic [TAG_W-1:0] t;
		d = q_dl[a]; t = q_tag[a];
		q_dl[a] = q_dl[b]; q_tag[a] = q_tag[b];
		q_dl[b] = d; q_tag[b] = t;
	endfunction

	function automatic void q_push(input logic [TIME_W-1:0] dl, input logic [TAG_W-1:0] tag);
		int i;
		int p;
		i = q_cnt;
		q_dl[i] = dl;
		q_tag[i] = tag;
		q_cnt++;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (q_dl[i] < q_dl[p]) begin
				q_swap(i, p);
				i = p;
			end else break;
		end
	endfunction

	function automatic void q_pop();
		int i;
		int l;
		int m;
		i = 0;
		q_cnt--;
		q_dl[0] = q_dl[q_cnt];
		q_tag[0] = q_tag[q_cnt];
		forever begin
			l = 2 * i + 1;
			if (l >= q_cnt) break;
			m = l;
			if (l + 1 < q_cnt && q_dl[l + 1] < q_dl[l]) m = l + 1;
			if (q_dl[m] < q_dl[i]) begin
				q_swap(i, m);
				i = m;
			end else break;
		end
	endfunction

	function automatic res_t schedule(input item_t it);
		res_t r;
		logic [TIME_W-1:0] first;
		logic [TIME_W-1:0] d;
		logic [TAG_W-1:0] tag;
		int s;
		r = '0;
		first = it.relative ? sat_add(it.now, it.deadline) : it.deadline;
		if (it.cmd == CMD_REG) begin
			if (q_cnt >= HEAP_DEPTH) r.status = ST_HEAP_FULL;
			else begin
				for (s = 0; s < TIMER_SLOTS; s++) if (!slot_live[s]) break;
				if (s >= TIMER_SLOTS) r.status = ST_NO_SLOT;
				else begin
					slot_live[s] = 1'b1;
					slot_per[s] = it.period;
					slot_low[s] = it.kind_flag;
					q_push(first, {slot_stmp[s], SLOT_W'(s)});
					r.status = ST_REGISTERED;
					r.timer_id_res = 5'(s);
				end
			end
		end else if (it.cmd == CMD_REARM || it.cmd == CMD_REL) begin
			r.timer_id_res = it.timer_id;
			if (!slot_live[it.timer_id]) r.status = ST_BAD_ID;
			else if (it.cmd == CMD_REL) begin
				slot_live[it.timer_id] = 1'b0;
				slot_stmp[it.timer_id]++;
				r.status = ST_RELEASED;
			end else if (q_cnt >= HEAP_DEPTH) r.status = ST_HEAP_FULL;
			else begin
				slot_stmp[it.timer_id]++;
				if (!it.keep_period) slot_per[it.timer_id] = it.period;
				q_push(first, {slot_stmp[it.timer_id], it.timer_id});
				r.status = ST_REARMED;
			end
		end else begin
			while (q_cnt > 0 && it.now >= q_dl[0]) begin
				d = q_dl[0];
				tag = q_tag[0];
				s = int'(tag[SLOT_W-1:0]);
				q_pop();
				if (!slot_live[s] || slot_stmp[s] != tag[TAG_W-1:SLOT_W]) continue;
				r.fire_period = slot_per[s];
				if (slot_per[s] != 0) q_push(sat_add(d, slot_per[s]), tag);
				r.status = ST_FIRED;
				r.timer_id_res = 5'(s);
				r.fire_time = it.now;
				r.fire_kind = slot_low[s];
				break;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t w;
		if (!arst_n) begin
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				slot_live[i] = 1'b0;
				slot_stmp[i] = '0;
			end
			q_cnt = 0;
			errors = 0;
			fired_cnt = 0;
			expected_q.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected result", '0, '0);
				end else begin
					w = expected_q.pop_front();
					if (rsp_data.status != w.status)
						report("status", TIME_W'(rsp_data.status), TIME_W'(w.status));
					if (rsp_data.timer_id_res != w.timer_id_res)
						report("timer_id_res", TIME_W'(rsp_data.timer_id_res),
							TIME_W'(w.timer_id_res));
					if (rsp_data.fire_time != w.fire_time)
						report("fire_time", rsp_data.fire_time, w.fire_time);
					if (rsp_data.fire_period != w.fire_period)
						report("fire_period", rsp_data.fire_period, w.fire_period);
					if (rsp_data.fire_kind != w.fire_kind)
						report("fire_kind", TIME_W'(rsp_data.fire_kind), TIME_W'(w.fire_kind));
					if (w.status == ST_FIRED) fired_cnt++;
				end
			end
			if (req_valid && req_ready)
				expected_q.insert(expected_q.size(), schedule(req_data));
		end
	end
endmodule

// ===== tb/tb.sv =====
// Testbench top: drives commands into the timer scheduler and gives the verdict
`timescale 1ns / 1ps
module tb;
	import pths_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_W = $bits(item_t);
	localparam logic [TIME_W-1:0] TMAX = '1;

	logic clk;
	logic arst_n;
	int errors;
	int pending;
	int fired_cnt;
	int cycles;
	bit calm;
	logic [TIME_W-1:0] now_t;
	int sent;

	pths_req_if req ();
	pths_rsp_if rsp ();

	periodic_timer_heap_scheduler_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	pths_checker u_chk (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.req_data(req.data),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.rsp_data(rsp.data),
		.errors(errors),
		.pending(pending),
		.fired_cnt(fired_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp.ready <= calm || ($urandom_range(99) >= 17);
		end
	end

	function automatic logic [TIME_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send(input item_t it);
		while (!calm && $urandom_range(99) < 17) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.data <= it;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	function automatic item_t mk(input logic [1:0] c, input logic [4:0] id,
			input logic [TIME_W-1:0] dl, input logic rel, input logic [TIME_W-1:0] per,
			input logic keep, input logic low, input logic [TIME_W-1:0] nw);
		item_t it;
		it.cmd = c; it.timer_id = id; it.deadline = dl; it.relative = rel;
		it.period = per; it.keep_period = keep; it.kind_flag = low; it.now = nw;
		return it;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		int k;
		it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		k = $urandom_range(99);
		if (k < 3) return it;
		now_t += 64'($urandom_range(40));
		it.now = now_t;
		it.deadline = ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(200));
		it.relative = ($urandom_range(3) != 0) ? 1'b1 : 1'($urandom_range(1));
		if (!it.relative && it.deadline < 300) it.deadline += now_t;
		it.period = ($urandom_range(9) == 0) ? rand64() :
			($urandom_range(3) == 0) ? 64'd0 : 64'($urandom_range(120));
		it.timer_id = ($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(11));
		if (k < 28) it.cmd = CMD_REG;
		else if (k < 45) it.cmd = CMD_REARM;
		else if (k < 55) it.cmd = CMD_REL;
		else it.cmd = CMD_PUMP;
		return it;
	endfunction

	initial begin
		req.valid = 1'b0;
		req.data = '0;
		calm = 1'b0;
		sent = 0;
		now_t = 64'd1000;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(mk(CMD_PUMP, '0, '0, '0, '0, '0, '0, '0));
		send(mk(CMD_REARM, 5'd3, '0, '0, '0, '0, '0, '0));
		send(mk(CMD_REL, 5'd31, '0, '0, '0, '0, '0, '0));
		send(mk(CMD_REG, '0, 64'd10, '0, 64'd5, '0, 1'b1, '0));
		send(mk(CMD_REG, '0, 64'd10, '0, 64'd0, '0, '0, '0));
		send(mk(CMD_REG, '0, TMAX, 1'b1, TMAX, '0, 1'b1, TMAX));
		send(mk(CMD_REG, '0, 64'd20, 1'b1, TMAX, '0, '0, 64'd1));
		send(mk(CMD_PUMP, '0, '0, '0, '0, '0, '0, 64'd9));
		send(mk(CMD_PUMP, '0, '0, '0, '0, '0, '0, 64'd10));
		send(mk(CMD_PUMP, '0, '0, '0, '0, '0, '0, 64'd10));
		send(mk(CMD_PUMP, '0, '0, '0, '0, '0, '0, 64'd30));
		send(mk(CMD_REARM, '0, 64'd2, 1'b1, 64'd77, 1'b1, '0, 64'd30));
		send(mk(CMD_REARM, 5'd1, 64'd40, '0, 64'd3, '0, '0, 64'd30));
		send(mk(CMD_REL, '0, '0, '0, '0, '0, '0, '0));
		send(mk(CMD_REG, '0, 64'd35, '0, 64'd1, '0, 1'b1, '0));
		send(mk(CMD_PUMP, '0, '0, '0, '0, '0, '0, 64'd100));
		send(mk(CMD_PUMP, '0, '0, '0, '0, '0, '0, TMAX));
		send(mk(CMD_PUMP, '0, '0, '0, '0, '0, '0, TMAX));
		for (int i = 0; i < 33; i++) send(mk(CMD_REG, '0, TMAX, '0, '0, '0, i[0], '0));
		for (int i = 0; i < 34; i++) send(mk(CMD_REARM, 5'(i), TMAX, '0, '0, 1'b1, '0, '0));
		for (int i = 0; i < 32; i++) send(mk(CMD_REL, 5'(i), '0, '0, '0, '0, '0, '0));
		for (int i = 0; i < 70; i++) send(mk(CMD_PUMP, '0, '0, '0, '0, '0, '0, TMAX));

		for (int n = 0; n < 963; n++) begin
			calm = (n >= 400 && n < 550);
			send(rand_item());
		end
		req.valid <= 1'b0;
		calm = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("sent %0d commands, %0d timer firings observed", sent, fired_cnt);
		$display("covered full heap, no free slot, bad ids, stale entries, saturation");
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// ===== periodic_timer_heap_scheduler_core.f =====
+incdir+hw/rtl
hw/rtl/pths_pkg.sv
hw/rtl/pths_if.sv
hw/rtl/pths_ctrl.sv
hw/rtl/pths_dp.sv
hw/rtl/periodic_timer_heap_scheduler_core.sv
tb/pths_checker.sv
tb/tb.sv
